FILE: design/nbbf_pkg.sv
// Shared types and constants for the nonblack bounding box finder.
package nbbf_pkg;

   // Largest frame dimension the block supports
   localparam int MAX_DIMENSION = 4096;

   // Coordinate and dimension widths
   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;

   // Reset values of the frame size registers
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

   // Register indexes on the configuration port
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Result status codes
   localparam logic STATUS_FOUND = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // One input pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   // One frame result
   typedef struct packed {
      logic               status;
      logic [COORD_W-1:0] top_margin;
      logic [COORD_W-1:0] bottom_margin;
      logic [COORD_W-1:0] left_margin;
      logic [COORD_W-1:0] right_margin;
      logic [DIM_W-1:0]   crop_width;
      logic [DIM_W-1:0]   crop_height;
   } rsp_type;

   // Map a configured dimension onto the supported range
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] result;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > DIM_W'(MAX_DIMENSION)) begin
         result = DIM_W'(MAX_DIMENSION);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

FILE: design/nonblack_bounding_box_finder_unit.sv
// Top level of the nonblack bounding box finder.
//
// Usage: pixels of a frame arrive on the req_ channel in raster order, one
// transfer per pixel; a pixel is content when red, green or blue is nonzero.
// frame_width and frame_height are written on the csr_ port (always ready)
// while no pixel is in flight. On the last pixel of each frame one result
// transfer appears on the rsp_ channel: margins and crop size of the content
// box, or status empty with all other fields zero.
// Latency: the result is valid the cycle after the last pixel is taken.
// Throughput: one pixel per cycle while no frame-closing pixel is stalled;
// the single result register and the bound update before it set this figure.
// Receiver stall: the result holds; pixels keep flowing, and only the last
// pixel of the next frame is stalled while the previous result is unread.
// Reset: counters and the content flag clear, the size registers return to
// 1920 by 1080 and no result is pending.
module nonblack_bounding_box_finder_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  nbbf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output nbbf_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nbbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nbbf_pkg::DIM_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [nbbf_pkg::DIM_W-1:0] width_ff, width_in;
   logic [nbbf_pkg::DIM_W-1:0] height_ff, height_in;

   // Position and bound state
   logic [nbbf_pkg::COORD_W-1:0] column_count_ff, column_count_in;
   logic [nbbf_pkg::COORD_W-1:0] row_count_ff, row_count_in;
   logic [nbbf_pkg::COORD_W-1:0] min_row_ff, min_row_in;
   logic [nbbf_pkg::COORD_W-1:0] max_row_ff, max_row_in;
   logic [nbbf_pkg::COORD_W-1:0] min_col_ff, min_col_in;
   logic [nbbf_pkg::COORD_W-1:0] max_col_ff, max_col_in;
   logic                         seen_content_ff, seen_content_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   nbbf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [nbbf_pkg::DIM_W-1:0] eff_width;
   logic [nbbf_pkg::DIM_W-1:0] eff_height;
   logic                       content;
   logic                       row_end;
   logic                       frame_end;
   logic                       req_take;

   // Frame geometry of the current pixel
   always_comb begin
      eff_width  = nbbf_pkg::clamp_dim(width_ff);
      eff_height = nbbf_pkg::clamp_dim(height_ff);
      content    = (req_data.red != 8'd0) || (req_data.green != 8'd0) ||
                   (req_data.blue != 8'd0);
      row_end    = ({1'b0, column_count_ff} + nbbf_pkg::DIM_W'(1)) >= eff_width;
      frame_end  = row_end &&
                   (({1'b0, row_count_ff} + nbbf_pkg::DIM_W'(1)) >= eff_height);
   end

   // Stall only the frame-closing pixel while the last result is unread
   assign req_stall = rsp_valid_ff && rsp_stall && frame_end;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            nbbf_pkg::CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            nbbf_pkg::CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Bounds, counters and result for one pixel
   always_comb begin
      logic [nbbf_pkg::DIM_W-1:0] bottom_full;
      logic [nbbf_pkg::DIM_W-1:0] right_full;

      min_row_in      = min_row_ff;
      max_row_in      = max_row_ff;
      min_col_in      = min_col_ff;
      max_col_in      = max_col_ff;
      seen_content_in = seen_content_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      bottom_full     = '0;
      right_full      = '0;

      // Grow the box, or open it on the first content pixel
      if (content) begin
         if (!seen_content_ff) begin
            min_row_in = row_count_ff;
            max_row_in = row_count_ff;
            min_col_in = column_count_ff;
            max_col_in = column_count_ff;
         end else begin
            if (row_count_ff < min_row_ff) min_row_in = row_count_ff;
            if (row_count_ff > max_row_ff) max_row_in = row_count_ff;
            if (column_count_ff < min_col_ff) min_col_in = column_count_ff;
            if (column_count_ff > max_col_ff) max_col_in = column_count_ff;
         end
         seen_content_in = 1'b1;
      end

      // Margins clip at zero when the frame shrank under the box
      if ({1'b0, max_row_in} < eff_height) begin
         bottom_full = eff_height - nbbf_pkg::DIM_W'(1) - {1'b0, max_row_in};
      end
      if ({1'b0, max_col_in} < eff_width) begin
         right_full = eff_width - nbbf_pkg::DIM_W'(1) - {1'b0, max_col_in};
      end

      if (req_take) begin
         if (frame_end) begin
            // Close the frame and load the result
            rsp_valid_in = 1'b1;
            if (seen_content_in) begin
               rsp_data_in.status        = nbbf_pkg::STATUS_FOUND;
               rsp_data_in.top_margin    = min_row_in;
               rsp_data_in.bottom_margin = bottom_full[nbbf_pkg::COORD_W-1:0];
               rsp_data_in.left_margin   = min_col_in;
               rsp_data_in.right_margin  = right_full[nbbf_pkg::COORD_W-1:0];
               rsp_data_in.crop_width    = {1'b0, max_col_in} - {1'b0, min_col_in}
                                           + nbbf_pkg::DIM_W'(1);
               rsp_data_in.crop_height   = {1'b0, max_row_in} - {1'b0, min_row_in}
                                           + nbbf_pkg::DIM_W'(1);
            end else begin
               rsp_data_in        = '0;
               rsp_data_in.status = nbbf_pkg::STATUS_EMPTY;
            end
            column_count_in = '0;
            row_count_in    = '0;
            seen_content_in = 1'b0;
         end else if (row_end) begin
            column_count_in = '0;
            row_count_in    = row_count_ff + nbbf_pkg::COORD_W'(1);
         end else begin
            column_count_in = column_count_ff + nbbf_pkg::COORD_W'(1);
         end
      end else begin
         // Drop any update from a pixel that was not taken
         min_row_in      = min_row_ff;
         max_row_in      = max_row_ff;
         min_col_in      = min_col_ff;
         max_col_in      = max_col_ff;
         seen_content_in = seen_content_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= nbbf_pkg::WIDTH_RESET;
         height_ff       <= nbbf_pkg::HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         seen_content_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         width_ff        <= width_in;
         height_ff       <= height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         seen_content_ff <= seen_content_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Bounds and result payload
   always_ff @(posedge clock) begin
      min_row_ff  <= min_row_in;
      max_row_ff  <= max_row_in;
      min_col_ff  <= min_col_in;
      max_col_ff  <= max_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The frame-closing pixel restarts the raster and presents a result
   assert property (@(posedge clock) disable iff (reset)
      req_take && frame_end |=> rsp_valid_ff && (column_count_ff == '0) &&
                                (row_count_ff == '0) && !seen_content_ff)
      else $error("frame end did not restart the raster with a result");

   // An empty frame reports a zero box
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == nbbf_pkg::STATUS_EMPTY) |->
         (rsp_data_ff.crop_width == '0) && (rsp_data_ff.crop_height == '0) &&
         (rsp_data_ff.top_margin == '0) && (rsp_data_ff.left_margin == '0))
      else $error("empty frame reported a nonzero box");

   // A found box is never empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == nbbf_pkg::STATUS_FOUND) |->
         (rsp_data_ff.crop_width != '0) && (rsp_data_ff.crop_height != '0))
      else $error("found box has zero size");

   // A pixel taken inside a frame leaves a stalled result untouched
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && !(req_take && frame_end) |=>
         rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result changed");
`endif

endmodule
